// ===== rtl/feathered_seam_blend_macros.svh =====
// assertion helpers for the seam blend block
`ifndef FEATHERED_SEAM_BLEND_MACROS_SVH
`define FEATHERED_SEAM_BLEND_MACROS_SVH
`ifndef ASSERT_OFF
`define FSB_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("seam blend check failed");
`define FSB_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("seam blend check failed");
`else
`define FSB_ASSERT(lbl, prop)
`define FSB_ASSERT_IMP(lbl, pre, post)
`endif
`endif

// ===== rtl/fsb_pkg.sv =====
package fsb_pkg;

   localparam int DIV_W  = 32;
   localparam int DEN_W  = 16;
   localparam int SIDE_W = 96;
   localparam int NUM_PTS = 4;

   localparam logic [16:0] Q_ONE  = 17'd32768;
   localparam logic [16:0] Q_HALF = 17'd16384;

   typedef enum logic [2:0] {
      REG_DIRECTION,
      REG_OVERLAP,
      REG_ALONG_LEN,
      REG_FEATHER,
      REG_POINT_CNT,
      REG_POINTS_LO,
      REG_POINTS_HI
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic [SIDE_W-1:0] side;
   } div_tag_type;

endpackage

// ===== rtl/feathered_seam_blend.sv =====
// feathered seam blend: one pixel request per clock, always; busy never rises and a
// request is taken at every edge with start high. the blended pixel appears on
// rsp_blended_pixel with rsp_valid in request order, after passing three 32-stage
// divider pipelines (along normalizing, seam point interpolation, feather ramp) plus
// eight single stages. results cannot be held off, so capture each one in the
// cycle rsp_valid is high. change csr registers only while no request is in flight.
`include "feathered_seam_blend_macros.svh"
module feathered_seam_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_across_pos,
   input  logic [11:0] req_along_pos,
   input  logic [31:0] req_first_pixel,
   input  logic [31:0] req_second_pixel,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output logic        rsp_valid,
   output logic [31:0] rsp_blended_pixel
);
   import fsb_pkg::*;

   // configuration registers
   logic        direction_ff;
   logic [10:0] overlap_ff;
   logic [12:0] along_len_ff;
   logic [10:0] feather_ff;
   logic [2:0]  point_cnt_ff;
   logic [63:0] points_lo_ff;
   logic [63:0] points_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         overlap_ff   <= 11'd64;
         along_len_ff <= 13'd4096;
         feather_ff   <= 11'd0;
         point_cnt_ff <= 3'd2;
         points_lo_ff <= 64'h4000800040000000;
         points_hi_ff <= 64'd0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            REG_DIRECTION: direction_ff <= csr_wdata[0];
            REG_OVERLAP:   overlap_ff   <= csr_wdata[10:0];
            REG_ALONG_LEN: along_len_ff <= csr_wdata[12:0];
            REG_FEATHER:   feather_ff   <= csr_wdata[10:0];
            REG_POINT_CNT: point_cnt_ff <= csr_wdata[2:0];
            REG_POINTS_LO: points_lo_ff <= csr_wdata;
            REG_POINTS_HI: points_hi_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // pipeline never stalls; direction is kept for software only
   assign busy = direction_ff & 1'b0;

   // along normalizing: along * 1.0 / (along_length - 1)
   logic [12:0]      denom;
   div_tag_type      d1_in_tag, d1_out_tag;
   logic [DIV_W-1:0] d1_quot;
   logic [DEN_W-1:0] d1_rem;

   assign denom = (along_len_ff > 13'd1) ? (along_len_ff - 13'd1) : 13'd1;
   assign d1_in_tag.valid = start;
   assign d1_in_tag.side  = {22'd0, req_across_pos, req_second_pixel, req_first_pixel};

   fsb_div u_div_along (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (d1_in_tag),
      .in_num   ({5'd0, req_along_pos, 15'd0}),
      .in_den   ({3'd0, denom}),
      .out_tag  (d1_out_tag),
      .out_quot (d1_quot),
      .out_rem  (d1_rem)
   );

   // bracket search over the seam points
   logic [15:0] pt_along  [NUM_PTS];
   logic [15:0] pt_across [NUM_PTS];
   logic [2:0]  n_eff;
   logic [2:0]  up;
   logic        found;
   logic [1:0]  lo_idx;
   logic [1:0]  hi_idx;
   logic [15:0] bk_c0_in, bk_dc_in, bk_span_in, bk_num_in;
   logic        bk_down_in;

   always_comb begin
      for (int i = 0; i < NUM_PTS; i++) begin
         if (i < 2) begin
            pt_along[i]  = points_lo_ff[32*i +: 16];
            pt_across[i] = points_lo_ff[32*i+16 +: 16];
         end else begin
            pt_along[i]  = points_hi_ff[32*(i-2) +: 16];
            pt_across[i] = points_hi_ff[32*(i-2)+16 +: 16];
         end
      end
   end

   always_comb begin
      priority if (point_cnt_ff < 3'd2) begin
         n_eff = 3'd2;
      end else if (point_cnt_ff > 3'(NUM_PTS)) begin
         n_eff = 3'(NUM_PTS);
      end else begin
         n_eff = point_cnt_ff;
      end
      up    = n_eff;
      found = 1'b0;
      for (int i = 0; i < NUM_PTS; i++) begin
         if (!found && (3'(i) < n_eff) && (d1_quot < {16'd0, pt_along[i]})) begin
            up    = 3'(i);
            found = 1'b1;
         end
      end
      hi_idx = up[1:0];
      lo_idx = 2'(up - 3'd1);
      bk_c0_in   = pt_across[lo_idx];
      bk_dc_in   = 16'd0;
      bk_span_in = 16'd1;
      bk_num_in  = 16'd0;
      bk_down_in = 1'b0;
      priority if (up == 3'd0) begin
         // before the first point
         bk_c0_in = pt_across[0];
      end else if (up == n_eff) begin
         // past the last point
         bk_c0_in = pt_across[lo_idx];
      end else if (pt_along[hi_idx] > pt_along[lo_idx]) begin
         bk_span_in = pt_along[hi_idx] - pt_along[lo_idx];
         bk_num_in  = 16'(d1_quot - {16'd0, pt_along[lo_idx]});
         bk_down_in = pt_across[hi_idx] < pt_across[lo_idx];
         bk_dc_in   = bk_down_in ? (pt_across[lo_idx] - pt_across[hi_idx])
                                 : (pt_across[hi_idx] - pt_across[lo_idx]);
      end else begin
         // zero span keeps the lower point
         bk_c0_in = pt_across[lo_idx];
      end
   end

   logic        bk_vld_ff;
   logic [15:0] bk_c0_ff, bk_dc_ff, bk_span_ff, bk_num_ff;
   logic        bk_down_ff;
   logic [73:0] bk_side_ff;

   always_ff @(posedge clock) begin
      bk_c0_ff   <= bk_c0_in;
      bk_dc_ff   <= bk_dc_in;
      bk_span_ff <= bk_span_in;
      bk_num_ff  <= bk_num_in;
      bk_down_ff <= bk_down_in;
      bk_side_ff <= d1_out_tag.side[73:0];
      if (reset) begin
         bk_vld_ff <= 1'b0;
      end else begin
         bk_vld_ff <= d1_out_tag.valid;
      end
   end

   // interpolation product
   logic        mu_vld_ff;
   logic [31:0] mu_prod_ff;
   logic [15:0] mu_span_ff;
   logic [90:0] mu_side_ff;

   always_ff @(posedge clock) begin
      mu_prod_ff <= bk_dc_ff * bk_num_ff;
      mu_span_ff <= bk_span_ff;
      mu_side_ff <= {bk_down_ff, bk_c0_ff, bk_side_ff};
      if (reset) begin
         mu_vld_ff <= 1'b0;
      end else begin
         mu_vld_ff <= bk_vld_ff;
      end
   end

   div_tag_type      d2_in_tag, d2_out_tag;
   logic [DIV_W-1:0] d2_quot;
   logic [DEN_W-1:0] d2_rem;

   assign d2_in_tag.valid = mu_vld_ff;
   assign d2_in_tag.side  = {5'd0, mu_side_ff};

   fsb_div u_div_interp (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (d2_in_tag),
      .in_num   (mu_prod_ff),
      .in_den   (mu_span_ff),
      .out_tag  (d2_out_tag),
      .out_quot (d2_quot),
      .out_rem  (d2_rem)
   );

   // seam across fraction, truncated toward the lower point
   logic        aq_vld_ff;
   logic [15:0] aq_ff;
   logic [73:0] aq_side_ff;
   logic [15:0] d2_c0;

   assign d2_c0 = d2_out_tag.side[89:74];

   always_ff @(posedge clock) begin
      aq_ff      <= d2_out_tag.side[90] ? (d2_c0 - d2_quot[15:0]) : (d2_c0 + d2_quot[15:0]);
      aq_side_ff <= d2_out_tag.side[73:0];
      if (reset) begin
         aq_vld_ff <= 1'b0;
      end else begin
         aq_vld_ff <= d2_out_tag.valid;
      end
   end

   // seam center in q.15 pixels
   logic [10:0] scale;
   logic        ce_vld_ff;
   logic [26:0] ce_ff;
   logic [73:0] ce_side_ff;

   assign scale = (overlap_ff != 11'd0) ? (overlap_ff - 11'd1) : 11'd0;

   always_ff @(posedge clock) begin
      ce_ff      <= aq_ff * scale;
      ce_side_ff <= aq_side_ff;
      if (reset) begin
         ce_vld_ff <= 1'b0;
      end else begin
         ce_vld_ff <= aq_vld_ff;
      end
   end

   // signed distance from the center
   logic [26:0] x_pos;
   logic        df_vld_ff;
   logic        df_neg_ff;
   logic [26:0] df_mag_ff;
   logic [63:0] df_pix_ff;

   assign x_pos = {2'd0, ce_side_ff[73:64], 15'd0};

   always_ff @(posedge clock) begin
      df_neg_ff <= x_pos < ce_ff;
      df_mag_ff <= (x_pos < ce_ff) ? (ce_ff - x_pos) : (x_pos - ce_ff);
      df_pix_ff <= ce_side_ff[63:0];
      if (reset) begin
         df_vld_ff <= 1'b0;
      end else begin
         df_vld_ff <= ce_vld_ff;
      end
   end

   div_tag_type      d3_in_tag, d3_out_tag;
   logic [DIV_W-1:0] d3_quot;
   logic [DEN_W-1:0] d3_rem;

   assign d3_in_tag.valid = df_vld_ff;
   assign d3_in_tag.side  = {31'd0, df_neg_ff, df_pix_ff};

   fsb_div u_div_feather (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (d3_in_tag),
      .in_num   ({5'd0, df_mag_ff}),
      .in_den   ({5'd0, feather_ff}),
      .out_tag  (d3_out_tag),
      .out_quot (d3_quot),
      .out_rem  (d3_rem)
   );

   // weight of the second image, clamped to 0..1.0
   logic        d3_neg;
   logic [32:0] ceil_q;
   logic [16:0] wt_in;

   assign d3_neg = d3_out_tag.side[64];
   assign ceil_q = {1'b0, d3_quot} + {32'd0, d3_rem != 16'd0};

   always_comb begin
      priority if (feather_ff == 11'd0) begin
         wt_in = d3_neg ? 17'd0 : Q_ONE;
      end else if (!d3_neg) begin
         wt_in = (d3_quot >= 32'(Q_HALF)) ? Q_ONE : (Q_HALF + d3_quot[16:0]);
      end else begin
         wt_in = (ceil_q >= 33'(Q_HALF)) ? 17'd0 : (Q_HALF - ceil_q[16:0]);
      end
   end

   logic        wt_vld_ff;
   logic [16:0] wt_ff;
   logic [63:0] wt_pix_ff;

   always_ff @(posedge clock) begin
      wt_ff     <= wt_in;
      wt_pix_ff <= d3_out_tag.side[63:0];
      if (reset) begin
         wt_vld_ff <= 1'b0;
      end else begin
         wt_vld_ff <= d3_out_tag.valid;
      end
   end

   // per channel products
   logic        pr_vld_ff;
   logic [24:0] pr_a_ff [4];
   logic [24:0] pr_b_ff [4];

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 4; ch++) begin
         pr_a_ff[ch] <= wt_pix_ff[8*ch +: 8] * (Q_ONE - wt_ff);
         pr_b_ff[ch] <= wt_pix_ff[32+8*ch +: 8] * wt_ff;
      end
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else begin
         pr_vld_ff <= wt_vld_ff;
      end
   end

   // sum and round half up
   logic [31:0] out_in;
   logic [25:0] ch_sum [4];

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         ch_sum[ch] = {1'b0, pr_a_ff[ch]} + {1'b0, pr_b_ff[ch]} + 26'(Q_HALF);
         out_in[8*ch +: 8] = ch_sum[ch][22:15];
      end
   end

   logic        out_vld_ff;
   logic [31:0] out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= pr_vld_ff;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_blended_pixel = out_ff;

   `FSB_ASSERT(a_weight_range, !(wt_vld_ff && (wt_ff > Q_ONE)))
   `FSB_ASSERT_IMP(a_hard_cut, wt_vld_ff && (feather_ff == 11'd0), (wt_ff == 17'd0) || (wt_ff == Q_ONE))
   `FSB_ASSERT_IMP(a_interp_in_span, bk_vld_ff, (bk_num_ff < bk_span_ff) || (bk_dc_ff == 16'd0))
   `FSB_ASSERT_IMP(a_out_follows, rsp_valid, $past(wt_vld_ff, 2))

endmodule

// ===== rtl/fsb_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module fsb_div (
   input  logic                      clock,
   input  logic                      reset,
   input  fsb_pkg::div_tag_type      in_tag,
   input  logic [fsb_pkg::DIV_W-1:0] in_num,
   input  logic [fsb_pkg::DEN_W-1:0] in_den,
   output fsb_pkg::div_tag_type      out_tag,
   output logic [fsb_pkg::DIV_W-1:0] out_quot,
   output logic [fsb_pkg::DEN_W-1:0] out_rem
);
   import fsb_pkg::*;

   logic [DEN_W-1:0]  rem_ff [1:DIV_W];
   logic [DIV_W-1:0]  nq_ff  [1:DIV_W];
   logic [DEN_W-1:0]  den_ff [1:DIV_W];
   logic [SIDE_W-1:0] side_ff [1:DIV_W];
   logic              vld_ff [1:DIV_W];

   logic [DEN_W-1:0]  rem_in [1:DIV_W];
   logic [DIV_W-1:0]  nq_in  [1:DIV_W];

   always_comb begin
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] prev_rem;
      logic [DIV_W-1:0] prev_nq;
      logic [DEN_W-1:0] den;
      for (int k = 1; k <= DIV_W; k++) begin
         if (k == 1) begin
            prev_rem = '0;
            prev_nq  = in_num;
            den      = in_den;
         end else begin
            prev_rem = rem_ff[k-1];
            prev_nq  = nq_ff[k-1];
            den      = den_ff[k-1];
         end
         trial = {prev_rem, prev_nq[DIV_W-1]};
         if (trial >= {1'b0, den}) begin
            rem_in[k] = DEN_W'(trial - {1'b0, den});
            nq_in[k]  = {prev_nq[DIV_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[DEN_W-1:0];
            nq_in[k]  = {prev_nq[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= DIV_W; k++) begin
         rem_ff[k] <= rem_in[k];
         nq_ff[k]  <= nq_in[k];
         if (k == 1) begin
            den_ff[k]  <= in_den;
            side_ff[k] <= in_tag.side;
         end else begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (k == 1) begin
            vld_ff[k] <= in_tag.valid;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign out_tag.valid = vld_ff[DIV_W];
   assign out_tag.side  = side_ff[DIV_W];
   assign out_quot      = nq_ff[DIV_W];
   assign out_rem       = rem_ff[DIV_W];

endmodule
